@@ sv/gjls_pkg.sv @@
// shared types for the gauss-jordan linear solver
// used by gjls_ctrl, gjls_dp and gauss_jordan_linear_solver
package gjls_pkg;

  // source of the word written into the matrix store
  typedef enum logic [2:0] {
    WS_IN,
    WS_RDATA,
    WS_HOLD,
    WS_ONE,
    WS_ZERO,
    WS_DIV,
    WS_SUB
  } wsel_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic  rd;
    logic  wr;
    wsel_t wsel;
    logic  ld_best;
    logic  ld_hold;
    logic  ld_pivot;
    logic  ld_factor;
    logic  div_start;
    logic  mul_cap;
    logic  ld_out;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic cand_gt;
    logic rdata_zero;
    logic div_busy;
  } status_t;

endpackage

@@ sv/gauss_jordan_linear_solver.sv @@
// top level of the gauss-jordan linear solver with partial pivoting
// depends on gjls_pkg, gjls_ctrl and gjls_dp
//
//  channel   dir  handshake            payload
//  s_axis    in   s_tvalid/s_tready    s_tdata: element_value
//  m_axis    out  m_tvalid/m_tready    m_tdata: solution_value, unknown_index;
//                                      m_tlast: last_result; m_tuser: singular
//  cfg       in   cfg_we               cfg_wdata: system_size
//
// n*(n+1) load items are accepted while loading; the last starts the solve.
// the solve runs from the matrix store (one read port, one write port): a pivot scan,
// a row swap, each normalized entry in the serial divider (NUMW = 33 + FRACTION_BITS
// quotient bits), each eliminated entry by multiply-subtract, then the results in turn.
// reset is synchronous; size returns to 1 and the load count to zero.
// items are taken only while loading; a stalled result holds the sequencer.
module gauss_jordan_linear_solver #(
  parameter int MAX_UNKNOWNS  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,   // system_size
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // [31:0] element_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,     // [31:0] solution_value, [35:32] unknown_index
  output logic        m_tlast,     // last_result
  output logic        m_tuser      // singular
);
  import gjls_pkg::*;

  // store rows by power-of-two column blocks so the address is a concatenation
  localparam int CW = $clog2(MAX_UNKNOWNS + 1);
  localparam int RW = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
  localparam int AW = RW + CW;

  cmd_t               cmd;
  status_t            st;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] out_value;
  logic [3:0]         m_index;

  gjls_ctrl #(
    .MAX_UNKNOWNS(MAX_UNKNOWNS),
    .CW(CW),
    .RW(RW),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_valid(s_tvalid),
    .s_ready(s_tready),
    .m_valid(m_tvalid),
    .m_ready(m_tready),
    .m_index(m_index),
    .m_last(m_tlast),
    .m_sing(m_tuser),
    .cmd(cmd),
    .st(st),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr)
  );

  gjls_dp #(
    .FRACTION_BITS(FRACTION_BITS),
    .AW(AW)
  ) u_dp (
    .clk(clk),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .in_value(s_tdata),
    .st(st),
    .out_value(out_value)
  );

  // pack the result item, padded to whole bytes
  assign m_tdata = {4'b0000, m_index, out_value};

endmodule

@@ sv/gjls_dp.sv @@
// datapath of the solver: matrix store, pivot compare, divider, multiply-subtract
// depends on gjls_pkg
module gjls_dp #(
  parameter int FRACTION_BITS = 16,
  parameter int AW            = 9
) (
  input  logic                clk,
  input  gjls_pkg::cmd_t      cmd,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  logic signed [31:0]  in_value,
  output gjls_pkg::status_t   st,
  output logic signed [31:0]  out_value
);
  import gjls_pkg::*;

  localparam int DEPTH = 1 << AW;
  localparam int NUMW  = 33 + FRACTION_BITS;
  localparam int CNTW  = $clog2(NUMW + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic signed [31:0] hold;
  logic signed [31:0] pivot;
  logic signed [31:0] factor;
  logic        [32:0] best_mag;
  logic signed [63:0] prod;

  logic [NUMW-1:0] div_q;
  logic [32:0]     div_r;
  logic [32:0]     div_d;
  logic            div_neg;
  logic [CNTW-1:0] div_cnt;

  logic signed [32:0] rd_ext;
  logic        [32:0] rd_mag;
  logic signed [32:0] pv_ext;
  logic        [32:0] pv_mag;
  logic        [33:0] rem_s;
  logic signed [31:0] div_res;
  logic signed [63:0] prod_q;
  logic signed [64:0] diff;
  logic signed [31:0] sub_res;
  logic signed [31:0] wdata;

  assign rd_ext = 33'(rdata);
  assign rd_mag = rd_ext[32] ? 33'(-rd_ext) : 33'(rd_ext);
  assign pv_ext = 33'(pivot);
  assign pv_mag = pv_ext[32] ? 33'(-pv_ext) : 33'(pv_ext);
  assign rem_s  = {div_r, div_q[NUMW-1]};

  assign st.cand_gt    = rd_mag > best_mag;
  assign st.rdata_zero = rdata == 32'sd0;
  assign st.div_busy   = div_cnt != '0;

  // saturate the quotient magnitude back to 32 bits
  always_comb begin
    if (div_neg) begin
      if (div_q > NUMW'(64'h8000_0000)) div_res = 32'sh8000_0000;
      else div_res = 32'(-div_q);
    end else begin
      if (div_q > NUMW'(64'h7fff_ffff)) div_res = 32'sh7fff_ffff;
      else div_res = 32'(div_q);
    end
  end

  // truncate the product toward zero, then subtract with saturation
  always_comb begin
    prod_q = (prod + (prod[63] ? 64'((64'sd1 <<< FRACTION_BITS) - 64'sd1) : 64'sd0))
             >>> FRACTION_BITS;
    diff   = 65'(rdata) - 65'(prod_q);
    if (diff > 65'sd2147483647) sub_res = 32'sh7fff_ffff;
    else if (diff < -65'sd2147483648) sub_res = 32'sh8000_0000;
    else sub_res = 32'(diff);
  end

  always_comb begin
    case (cmd.wsel)
      WS_IN:    wdata = in_value;
      WS_RDATA: wdata = rdata;
      WS_HOLD:  wdata = hold;
      WS_ONE:   wdata = 32'(64'sd1 <<< FRACTION_BITS);
      WS_ZERO:  wdata = 32'sd0;
      WS_DIV:   wdata = div_res;
      WS_SUB:   wdata = sub_res;
      default:  wdata = 32'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) mem[wr_addr] <= wdata;
    if (cmd.rd) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_best)   best_mag  <= rd_mag;
    if (cmd.ld_hold)   hold      <= rdata;
    if (cmd.ld_pivot)  pivot     <= rdata;
    if (cmd.ld_factor) factor    <= rdata;
    if (cmd.mul_cap)   prod      <= 64'(rdata) * 64'(factor);
    if (cmd.ld_out)    out_value <= rdata;
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q   <= NUMW'(rd_mag) << FRACTION_BITS;
      div_r   <= '0;
      div_d   <= pv_mag;
      div_neg <= rdata[31] ^ pivot[31];
      div_cnt <= CNTW'(NUMW);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - CNTW'(1);
      if (rem_s >= {1'b0, div_d}) begin
        div_r <= 33'(rem_s - {1'b0, div_d});
        div_q <= {div_q[NUMW-2:0], 1'b1};
      end else begin
        div_r <= rem_s[32:0];
        div_q <= {div_q[NUMW-2:0], 1'b0};
      end
    end
  end

endmodule

@@ sv/gjls_ctrl.sv @@
// controller of the solver: load counters, pivot search, swap, normalize,
// eliminate and result sequencing; depends on gjls_pkg
module gjls_ctrl #(
  parameter int MAX_UNKNOWNS = 16,
  parameter int CW           = 5,
  parameter int RW           = 4,
  parameter int AW           = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               s_valid,
  output logic               s_ready,
  output logic               m_valid,
  input  logic               m_ready,
  output logic [3:0]         m_index,
  output logic               m_last,
  output logic               m_sing,
  output gjls_pkg::cmd_t     cmd,
  input  gjls_pkg::status_t  st,
  output logic [AW-1:0]      rd_addr,
  output logic [AW-1:0]      wr_addr
);
  import gjls_pkg::*;

  typedef enum logic [4:0] {
    ST_LOAD, ST_PK, ST_PKC, ST_PSCAN, ST_SWC,
    ST_SW0, ST_SW1, ST_SW2, ST_SW3,
    ST_PV, ST_PV1, ST_N0, ST_N1, ST_N2,
    ST_E0, ST_E1, ST_E2, ST_E3, ST_E4,
    ST_NEXTK, ST_O0, ST_O1, ST_O2
  } state_t;

  state_t state;
  logic [CW-1:0] n, r, c, k, i, j, best;
  logic          sing;
  logic [CW-1:0] rd_row, rd_col, wr_row, wr_col;
  logic [CW-1:0] n_cfg;

  assign rd_addr = {rd_row[RW-1:0], rd_col};
  assign wr_addr = {wr_row[RW-1:0], wr_col};

  assign s_ready = state == ST_LOAD;
  assign m_valid = state == ST_O2;
  assign m_index = 4'(i);
  assign m_last  = (i + CW'(1)) == n;
  assign m_sing  = sing;

  always_comb begin
    if (cfg_wdata == 5'd0) n_cfg = CW'(1);
    else if (32'(cfg_wdata) > MAX_UNKNOWNS) n_cfg = CW'(MAX_UNKNOWNS);
    else n_cfg = CW'(cfg_wdata);
  end

  always_comb begin
    cmd    = '0;
    rd_row = k;
    rd_col = k;
    wr_row = k;
    wr_col = j;
    unique case (state)
      ST_LOAD: begin
        cmd.wr   = s_valid;
        cmd.wsel = WS_IN;
        wr_row   = r;
        wr_col   = c;
      end
      ST_PK:  cmd.rd = 1'b1;
      ST_PKC: begin
        cmd.ld_best = 1'b1;
        cmd.rd      = (k + CW'(1)) < n;
        rd_row      = k + CW'(1);
      end
      ST_PSCAN: begin
        cmd.ld_best = st.cand_gt;
        cmd.rd      = (i + CW'(1)) < n;
        rd_row      = i + CW'(1);
      end
      ST_SWC: ;
      ST_SW0: begin
        cmd.rd = 1'b1;
        rd_col = j;
      end
      ST_SW1: begin
        cmd.ld_hold = 1'b1;
        cmd.rd      = 1'b1;
        rd_row      = best;
        rd_col      = j;
      end
      ST_SW2: begin
        cmd.wr   = 1'b1;
        cmd.wsel = WS_RDATA;
      end
      ST_SW3: begin
        cmd.wr   = 1'b1;
        cmd.wsel = WS_HOLD;
        wr_row   = best;
      end
      ST_PV: cmd.rd = 1'b1;
      ST_PV1: begin
        cmd.ld_pivot = 1'b1;
        cmd.wr       = !st.rdata_zero;
        cmd.wsel     = WS_ONE;
        wr_col       = k;
      end
      ST_N0: begin
        cmd.rd = 1'b1;
        rd_col = j;
      end
      ST_N1: cmd.div_start = 1'b1;
      ST_N2: begin
        cmd.wr   = !st.div_busy;
        cmd.wsel = WS_DIV;
      end
      ST_E0: begin
        cmd.rd = (i != k) && (i < n);
        rd_row = i;
      end
      ST_E1: begin
        cmd.ld_factor = 1'b1;
        cmd.wr        = 1'b1;
        cmd.wsel      = WS_ZERO;
        wr_row        = i;
        wr_col        = k;
      end
      ST_E2: begin
        cmd.rd = 1'b1;
        rd_col = j;
      end
      ST_E3: begin
        cmd.mul_cap = 1'b1;
        cmd.rd      = 1'b1;
        rd_row      = i;
        rd_col      = j;
      end
      ST_E4: begin
        cmd.wr   = 1'b1;
        cmd.wsel = WS_SUB;
        wr_row   = i;
      end
      ST_NEXTK: ;
      ST_O0: begin
        cmd.rd = 1'b1;
        rd_row = i;
        rd_col = n;
      end
      ST_O1: cmd.ld_out = 1'b1;
      ST_O2: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      n     <= CW'(1);
      r     <= '0;
      c     <= '0;
      k     <= '0;
      i     <= '0;
      j     <= '0;
      best  <= '0;
      sing  <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (s_valid) begin
            if (c == n) begin
              c <= '0;
              r <= r + CW'(1);
            end else begin
              c <= c + CW'(1);
            end
            if (r == n - CW'(1) && c == n) begin
              r     <= '0;
              c     <= '0;
              k     <= '0;
              sing  <= 1'b0;
              state <= ST_PK;
            end
          end
        end
        ST_PK: state <= ST_PKC;
        ST_PKC: begin
          best <= k;
          i    <= k + CW'(1);
          if ((k + CW'(1)) < n) state <= ST_PSCAN;
          else state <= ST_PV;
        end
        ST_PSCAN: begin
          if (st.cand_gt) best <= i;
          if ((i + CW'(1)) < n) i <= i + CW'(1);
          else state <= ST_SWC;
        end
        ST_SWC: begin
          j <= '0;
          if (best != k) state <= ST_SW0;
          else state <= ST_PV;
        end
        ST_SW0: state <= ST_SW1;
        ST_SW1: state <= ST_SW2;
        ST_SW2: state <= ST_SW3;
        ST_SW3: begin
          if (j == n) state <= ST_PV;
          else begin
            j     <= j + CW'(1);
            state <= ST_SW0;
          end
        end
        ST_PV: state <= ST_PV1;
        ST_PV1: begin
          if (st.rdata_zero) begin
            sing  <= 1'b1;
            state <= ST_NEXTK;
          end else begin
            j     <= k + CW'(1);
            state <= ST_N0;
          end
        end
        ST_N0: state <= ST_N1;
        ST_N1: state <= ST_N2;
        ST_N2: begin
          if (!st.div_busy) begin
            if (j == n) begin
              i     <= '0;
              state <= ST_E0;
            end else begin
              j     <= j + CW'(1);
              state <= ST_N0;
            end
          end
        end
        ST_E0: begin
          if (i >= n) state <= ST_NEXTK;
          else if (i == k) i <= i + CW'(1);
          else state <= ST_E1;
        end
        ST_E1: begin
          j     <= k + CW'(1);
          state <= ST_E2;
        end
        ST_E2: state <= ST_E3;
        ST_E3: state <= ST_E4;
        ST_E4: begin
          if (j == n) begin
            i     <= i + CW'(1);
            state <= ST_E0;
          end else begin
            j     <= j + CW'(1);
            state <= ST_E2;
          end
        end
        ST_NEXTK: begin
          if ((k + CW'(1)) == n) begin
            i     <= '0;
            state <= ST_O0;
          end else begin
            k     <= k + CW'(1);
            state <= ST_PK;
          end
        end
        ST_O0: state <= ST_O1;
        ST_O1: state <= ST_O2;
        ST_O2: begin
          if (m_ready) begin
            if ((i + CW'(1)) == n) state <= ST_LOAD;
            else begin
              i     <= i + CW'(1);
              state <= ST_O0;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
      // write size only while loading (unchecked); drops partial system
      if (cfg_we) begin
        n <= n_cfg;
        r <= '0;
        c <= '0;
      end
    end
  end

endmodule

@@ tb/gjls_checker.sv @@
// result checker for the gauss-jordan linear solver: tracks config writes and accepted
// items, solves each completed system in fixed point and compares the output items
// depends on the dut port widths only
`timescale 1ns / 100ps
module gjls_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  input  logic        m_tuser,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  idx;
    logic        last;
    logic        sing;
  } soln_t;

  localparam int MAXN = 16;
  localparam int FRAC = 16;

  logic signed [31:0] mtx [MAXN][MAXN+1];
  logic [4:0] size_reg;
  int load_cnt;
  soln_t solutions_q[$];

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic int eff_size();
    if (size_reg < 1) return 1;
    if (size_reg > MAXN) return MAXN;
    return size_reg;
  endfunction

  // gauss-jordan with partial pivoting; returns 1 on a zero pivot
  function automatic logic eliminate(int n);
    logic sing;
    int best;
    logic signed [63:0] bmag, m, f, prod;
    logic signed [31:0] tmp, p;
    sing = 0;
    for (int k = 0; k < n; k++) begin
      best = k;
      bmag = mtx[k][k];
      if (bmag < 0) bmag = -bmag;
      for (int i = k + 1; i < n; i++) begin
        m = mtx[i][k];
        if (m < 0) m = -m;
        if (m > bmag) begin
          bmag = m;
          best = i;
        end
      end
      if (best != k)
        for (int j = 0; j <= n; j++) begin
          tmp = mtx[k][j];
          mtx[k][j] = mtx[best][j];
          mtx[best][j] = tmp;
        end
      p = mtx[k][k];
      if (p == 0) begin
        sing = 1;
        continue;
      end
      mtx[k][k] = 32'sh00010000;
      for (int j = k + 1; j <= n; j++)
        mtx[k][j] = sat32((64'(mtx[k][j]) <<< FRAC) / 64'(p));
      for (int i = 0; i < n; i++) begin
        if (i == k) continue;
        f = mtx[i][k];
        for (int j = k + 1; j <= n; j++) begin
          prod = (64'(mtx[k][j]) * f) / 64'sd65536;
          mtx[i][j] = sat32(64'(mtx[i][j]) - prod);
        end
        mtx[i][k] = 0;
      end
    end
    return sing;
  endfunction

  assign pending = solutions_q.size();

  always @(posedge clk) begin
    int n;
    logic sing;
    soln_t got, want;
    if (rst) begin
      size_reg <= 5'd1;
      load_cnt = 0;
      fail_count <= 0;
      solutions_q.delete();
    end else begin
      if (cfg_we) begin
        size_reg <= cfg_wdata;
        load_cnt = 0;
      end else if (s_tvalid && s_tready) begin
        n = eff_size();
        mtx[load_cnt / (n + 1)][load_cnt % (n + 1)] = s_tdata;
        load_cnt++;
        if (load_cnt == n * (n + 1)) begin
          load_cnt = 0;
          sing = eliminate(n);
          for (int i = 0; i < n; i++)
            solutions_q.push_back('{mtx[i][n], 4'(i), i == n - 1, sing});
        end
      end
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[31:0], m_tdata[35:32], m_tlast, m_tuser};
        if (solutions_q.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = solutions_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected val=%h idx=%0d last=%b sing=%b,",
                     $time, want.value, want.idx, want.last, want.sing);
            $display("  actual val=%h idx=%0d last=%b sing=%b",
                     got.value, got.idx, got.last, got.sing);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb_top.sv @@
// stimulus top for the gauss-jordan linear solver: loads systems of several sizes,
// with bursty input, a stalling receiver and a checker module; depends on gjls_checker
`timescale 1ns / 100ps
module tb_top;
  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [4:0]  cfg_wdata = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  int          fail_count;
  int          pending;
  int          item_count = 0;
  bit          hold_off = 0;   // long receiver stall requested

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  gauss_jordan_linear_solver dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  gjls_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver: mostly ready, stall patterns vary, and a long hold-off on request
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(negedge clk);
        if (hold_off) m_tready <= 0;
        else case (mode)
          0: m_tready <= 1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // random values, mostly tame, with zeros and extremes in some styles
  function automatic logic [31:0] pick_value(int style);
    case (style)
      0: return $urandom();
      1: return {{12{1'b0}}, 20'($urandom())} ^ ($urandom_range(0, 1) ? 32'hffffffff : 0);
      2: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
      3: return 0;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h00000001;
          default: return 32'hffffffff;
        endcase
      end
    endcase
  endfunction

  // drive one item, keeping tvalid high across back-to-back items
  task automatic put_item(logic [31:0] v, bit gap_after);
    s_tvalid <= 1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    item_count++;
    @(negedge clk);
    if (gap_after) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // wait for every expected result, then the solver's tail
  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic set_size(logic [4:0] sz);
    cfg_we <= 1;
    cfg_wdata <= sz;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // one full system of effective size n with given value style and burst pacing
  task automatic load_system(int n, int style);
    int burst;
    burst = $urandom_range(1, 12);
    for (int i = 0; i < n * (n + 1); i++) begin
      burst--;
      put_item(pick_value(style), burst == 0);
      if (burst == 0) burst = $urandom_range(1, 12);
    end
  endtask

  initial begin
    int sz, n;
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: reset size 1, extremes, zero pivot
    put_item(32'h00020000, 0);
    put_item(32'h80000000, 0);
    put_item(32'h00000000, 0);
    put_item(32'h7fffffff, 1);
    drain();
    // size 0 acts as 1
    set_size(5'd0);
    put_item(32'hffffffff, 0);
    put_item(32'h7fffffff, 1);
    drain();
    // size 2 after a dropped partial load
    set_size(5'd2);
    put_item(32'h00010000, 0);
    put_item(32'h00010000, 1);
    drain();
    set_size(5'd2);
    for (int i = 0; i < 6; i++) put_item(i < 4 ? 32'h00010000 : 32'h00030000, 0);
    drain();
    // tie among equal magnitudes
    set_size(5'd2);
    put_item(32'hffff0000, 0); put_item(32'h00010000, 0); put_item(32'h00050000, 0);
    put_item(32'h00010000, 0); put_item(32'h00020000, 0); put_item(32'h00070000, 0);
    drain();

    // random systems; one large size early at most, sizes above 16 clamp
    while (item_count < 400) begin
      case ($urandom_range(0, 9))
        0: sz = (item_count < 100) ? 16 : $urandom_range(1, 5);
        1: sz = (item_count < 100) ? $urandom_range(17, 31) : $urandom_range(1, 5);
        default: sz = $urandom_range(1, 5);
      endcase
      n = sz > 16 ? 16 : sz;
      set_size(5'(sz));
      if (n <= 5 && $urandom_range(0, 7) == 0) begin
        // back-to-back systems while the receiver holds off
        hold_off = 1;
        fork
          begin
            repeat (1500) @(negedge clk);
            hold_off = 0;
          end
        join_none
        load_system(n, $urandom_range(0, 4));
        load_system(n, 2);
      end else begin
        load_system(n, $urandom_range(0, 4));
      end
      drain();
    end
    hold_off = 0;
    drain();
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #400ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/gjls_pkg.sv
sv/gjls_dp.sv
sv/gjls_ctrl.sv
sv/gauss_jordan_linear_solver.sv
tb/gjls_checker.sv
tb/tb_top.sv
